// ===== hdl/dfts_pkg.sv =====
// dfts_pkg: shared types, codes and defaults for the dmx512 frame transmit sequencer
// used by dfts_port_seq and dmx512_frame_transmit_sequencer_top; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package dfts_pkg;

    // default configuration
    localparam int DFTS_PORTS = 4;
    localparam int DFTS_SLOTS = 512;

    // field widths fixed by the word format
    localparam int CMD_W   = 2;
    localparam int PORT_W  = 2;
    localparam int ADDR_W  = 9;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int MASK_W  = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_WRITE    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENABLE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_FINISHED = 2'd2;

    // symbol kinds
    localparam logic [KIND_W-1:0] KIND_BREAK = 2'd0;
    localparam logic [KIND_W-1:0] KIND_START = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SLOT  = 2'd2;

    // break and start code byte
    localparam logic [BYTE_W-1:0] NULL_BYTE = 8'h00;

    // one input word, unpacked
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [PORT_W-1:0] port;
        logic [ADDR_W-1:0] slot_address;
        logic [BYTE_W-1:0] slot_value;
        logic              enable;
    } item_t;

    // result descriptor from the sequencer; slot byte comes from the store
    typedef struct packed {
        logic              emit;
        logic [PORT_W-1:0] port;
        logic              half_rate;
        logic [KIND_W-1:0] kind;
        logic              from_store;
    } result_t;

endpackage

`default_nettype wire

// ===== hdl/dfts_slot_mem.sv =====
// dfts_slot_mem: slot store, one write port and one registered read port
// runs a zeroing sweep over every entry after reset; no package dependency
`timescale 1ns / 1ps
`default_nettype none

module dfts_slot_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [7:0]    wr_data,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [7:0]    rd_data,
    output logic               clr_busy
);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rd_data_reg;
    logic          clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    // clearing sweep control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // storage write, sweep has the port while busy
    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            mem[clr_addr_reg] <= 8'h00;
        end
        else if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read, holds while idle
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data  = rd_data_reg;
    assign clr_busy = clr_busy_reg;

endmodule

`default_nettype wire

// ===== hdl/dfts_port_seq.sv =====
// dfts_port_seq: per-port frame state (run flag, phase, slot index) and next-symbol decision
// depends on dfts_pkg; drives the slot store addresses
`timescale 1ns / 1ps
`default_nettype none

module dfts_port_seq #(
    parameter int PORTS = 4,
    parameter int SLOTS = 512,
    parameter int AW    = 11
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire dfts_pkg::item_t        item,
    input  wire logic [dfts_pkg::MASK_W-1:0] port_mask,
    output dfts_pkg::result_t           result,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [7:0]                  wr_data,
    output logic                        rd_en,
    output logic [AW-1:0]               rd_addr
);

    import dfts_pkg::*;

    localparam int PW  = (PORTS > 1) ? $clog2(PORTS) : 1;
    localparam int SIW = $clog2(SLOTS);

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_BREAK = 2'd1,
        PH_START = 2'd2,
        PH_SLOTS = 2'd3
    } phase_t;

    logic           run_reg   [PORTS];
    phase_t         phase_reg [PORTS];
    logic [SIW-1:0] idx_reg   [PORTS];

    logic           in_range;
    logic           is_out;
    logic [PW-1:0]  pi;
    logic           cur_run;
    phase_t         cur_phase;
    logic [SIW-1:0] cur_idx;
    logic [SIW-1:0] idx_inc;
    logic [AW-1:0]  base;

    logic           upd;
    logic           run_next;
    phase_t         phase_next;
    logic [SIW-1:0] idx_next;
    logic [SIW-1:0] rd_slot;
    result_t        res;
    logic           rd_req;

    // port lookup
    assign in_range  = (32'(item.port) < PORTS);
    assign is_out    = port_mask[item.port];
    assign pi        = in_range ? PW'(item.port) : '0;
    assign cur_run   = run_reg[pi];
    assign cur_phase = phase_reg[pi];
    assign cur_idx   = idx_reg[pi];
    assign idx_inc   = cur_idx + 1'b1;
    assign base      = AW'(pi) * AW'(SLOTS);

    // next state and result for the addressed port
    always_comb
    begin
        upd        = 1'b0;
        run_next   = cur_run;
        phase_next = cur_phase;
        idx_next   = cur_idx;
        rd_slot    = '0;
        rd_req     = 1'b0;
        res        = '0;
        res.port   = item.port;
        if (in_range && is_out)
        begin
            unique case (item.cmd)
                CMD_ENABLE:
                begin
                    if (item.enable && !cur_run)
                    begin
                        upd           = 1'b1;
                        run_next      = 1'b1;
                        phase_next    = PH_BREAK;
                        idx_next      = '0;
                        res.emit      = 1'b1;
                        res.half_rate = 1'b1;
                        res.kind      = KIND_BREAK;
                    end
                    else if (!item.enable && cur_run)
                    begin
                        upd      = 1'b1;
                        run_next = 1'b0;
                    end
                end
                CMD_FINISHED:
                begin
                    unique case (cur_phase)
                        PH_BREAK:
                        begin
                            upd        = 1'b1;
                            phase_next = PH_START;
                            res.emit   = 1'b1;
                            res.kind   = KIND_START;
                        end
                        PH_START:
                        begin
                            upd = 1'b1;
                            if (!cur_run)
                            begin
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                phase_next     = PH_SLOTS;
                                idx_next       = '0;
                                rd_slot        = '0;
                                rd_req         = 1'b1;
                                res.emit       = 1'b1;
                                res.kind       = KIND_SLOT;
                                res.from_store = 1'b1;
                            end
                        end
                        PH_SLOTS:
                        begin
                            upd = 1'b1;
                            if (cur_idx != SIW'(SLOTS - 1))
                            begin
                                idx_next       = idx_inc;
                                rd_slot        = idx_inc;
                                rd_req         = 1'b1;
                                res.emit       = 1'b1;
                                res.kind       = KIND_SLOT;
                                res.from_store = 1'b1;
                            end
                            else
                            begin
                                idx_next = '0;
                                if (!cur_run)
                                begin
                                    phase_next = PH_IDLE;
                                end
                                else
                                begin
                                    phase_next    = PH_BREAK;
                                    res.emit      = 1'b1;
                                    res.half_rate = 1'b1;
                                    res.kind      = KIND_BREAK;
                                end
                            end
                        end
                        default:
                        begin
                            upd = 1'b0;
                        end
                    endcase
                end
                default:
                begin
                    upd = 1'b0;
                end
            endcase
        end
    end

    // per-port state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORTS; i++)
            begin
                run_reg[i]   <= 1'b0;
                phase_reg[i] <= PH_IDLE;
                idx_reg[i]   <= '0;
            end
        end
        else if (accept && upd)
        begin
            run_reg[pi]   <= run_next;
            phase_reg[pi] <= phase_next;
            idx_reg[pi]   <= idx_next;
        end
    end

    // slot store access, writes are taken whatever the mask says
    assign wr_en   = accept && in_range && (item.cmd == CMD_WRITE)
                     && (32'(item.slot_address) < SLOTS);
    assign wr_addr = base + AW'(SIW'(item.slot_address));
    assign wr_data = item.slot_value;
    assign rd_en   = accept && rd_req;
    assign rd_addr = base + AW'(rd_slot);
    assign result  = res;

endmodule

`default_nettype wire

// ===== hdl/dmx512_frame_transmit_sequencer_top.sv =====
// dmx512 frame transmit sequencer top: handshakes, port mask register, output register
// depends on dfts_pkg, dfts_slot_mem and dfts_port_seq
// result: registered, valid in the cycle after its input word is accepted
// throughput: one input word per cycle while s_axis_tready is high; at most one slot store read or write per word
// reset: rst_n async low clears port state and mask; the slot store is then zeroed entry by
//        entry over all PORTS*SLOTS entries (2048 by default) with s_axis_tready low
`timescale 1ns / 1ps
`default_nettype none

module dmx512_frame_transmit_sequencer_top #(
    parameter int PORTS = dfts_pkg::DFTS_PORTS,
    parameter int SLOTS = dfts_pkg::DFTS_SLOTS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // port mask write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [3:0]  cfg_data,      // output_port_mask
    // input words
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // port[1:0], slot_address[10:2],
                                            // slot_value[18:11], enable[19], zero[23:20]
    input  wire logic [1:0]  s_axis_tuser,  // cmd
    // result words
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // out_port[1:0], symbol_byte[9:2],
                                            // half_rate[10], zero[15:11]
    output logic [1:0]       m_axis_tuser   // symbol_kind
);

    import dfts_pkg::*;

    localparam int DEPTH = PORTS * SLOTS;
    localparam int AW    = $clog2(DEPTH);

    logic [MASK_W-1:0] mask_reg;
    item_t             item;
    logic              accept;
    logic              clr_busy;
    result_t           res;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [7:0]        wr_data;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [7:0]        rd_data;

    logic              out_valid_reg;
    logic [PORT_W-1:0] out_port_reg;
    logic              out_half_reg;
    logic [KIND_W-1:0] out_kind_reg;
    logic              out_store_reg;

    // port mask register
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mask_reg <= cfg_data;
        end
    end

    // unpack input word
    assign item.cmd          = s_axis_tuser;
    assign item.port         = s_axis_tdata[1:0];
    assign item.slot_address = s_axis_tdata[10:2];
    assign item.slot_value   = s_axis_tdata[18:11];
    assign item.enable       = s_axis_tdata[19];

    // take a word unless the slot store is clearing or the result register stays full
    assign s_axis_tready = !clr_busy && (!out_valid_reg || m_axis_tready);
    assign accept        = s_axis_tvalid && s_axis_tready;

    dfts_port_seq #(
        .PORTS (PORTS),
        .SLOTS (SLOTS),
        .AW    (AW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .port_mask (mask_reg),
        .result    (res),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_en     (rd_en),
        .rd_addr   (rd_addr)
    );

    dfts_slot_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .clr_busy (clr_busy)
    );

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= res.emit;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_port_reg  <= res.port;
            out_half_reg  <= res.half_rate;
            out_kind_reg  <= res.kind;
            out_store_reg <= res.from_store;
        end
    end

    // pack result word
    assign m_axis_tvalid       = out_valid_reg;
    assign m_axis_tdata[1:0]   = out_port_reg;
    assign m_axis_tdata[9:2]   = out_store_reg ? rd_data : NULL_BYTE;
    assign m_axis_tdata[10]    = out_half_reg;
    assign m_axis_tdata[15:11] = '0;
    assign m_axis_tuser        = out_kind_reg;

endmodule

`default_nettype wire

// ===== tb/dfts_symbol_checker.sv =====
// dfts_symbol_checker: watches the mask, input and result channels of the dmx512 sequencer,
// predicts the next symbol per port and compares every result word; depends on dfts_pkg
`timescale 1ns / 1ps

module dfts_symbol_checker #(
    parameter int PORTS = dfts_pkg::DFTS_PORTS,
    parameter int SLOTS = dfts_pkg::DFTS_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // port[1:0], slot_address[10:2],
                                        // slot_value[18:11], enable[19], zero[23:20]
    input  logic [1:0]  s_axis_tuser,   // cmd
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // out_port[1:0], symbol_byte[9:2], half_rate[10]
    input  logic [1:0]  m_axis_tuser,   // symbol_kind
    output int          errors,
    output int          pending
);

    import dfts_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_BREAK,
        PH_START,
        PH_SLOTS
    } frame_phase_t;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [BYTE_W-1:0] sym_byte;
        logic              half_rate;
        logic [KIND_W-1:0] kind;
    } symbol_t;

    // mirror of the sequencer state
    logic [MASK_W-1:0] port_mask;
    logic              port_running [PORTS];
    frame_phase_t      port_phase [PORTS];
    logic [ADDR_W-1:0] slot_pos [PORTS];
    logic [BYTE_W-1:0] frame_bytes [PORTS*SLOTS];

    symbol_t symbols_due [$];
    int      fail_count = 0;

    function automatic symbol_t make_symbol(input logic [PORT_W-1:0] p,
                                            input logic [BYTE_W-1:0] b,
                                            input logic h,
                                            input logic [KIND_W-1:0] k);
        symbol_t s;
        s.port      = p;
        s.sym_byte  = b;
        s.half_rate = h;
        s.kind      = k;
        return s;
    endfunction

    // advance one port by one input word; emits is set when a symbol follows
    task automatic advance_port(input item_t it, output bit emits, output symbol_t sym);
        int p;
        int base;
        p      = int'(it.port);
        base   = p * SLOTS;
        emits  = 1'b0;
        sym    = '0;
        if (p >= PORTS)
            return;
        if (it.cmd == CMD_WRITE)
        begin
            if (int'(it.slot_address) < SLOTS)
                frame_bytes[base + int'(it.slot_address)] = it.slot_value;
            return;
        end
        if (!port_mask[p])
            return;
        if (it.cmd == CMD_ENABLE)
        begin
            if (it.enable && !port_running[p])
            begin
                port_running[p] = 1'b1;
                port_phase[p]   = PH_BREAK;
                slot_pos[p]     = '0;
                emits = 1'b1;
                sym   = make_symbol(it.port, NULL_BYTE, 1'b1, KIND_BREAK);
            end
            else if (!it.enable && port_running[p])
                port_running[p] = 1'b0;
            return;
        end
        if (it.cmd != CMD_FINISHED)
            return;
        case (port_phase[p])
            PH_BREAK:
            begin
                port_phase[p] = PH_START;
                emits = 1'b1;
                sym   = make_symbol(it.port, NULL_BYTE, 1'b0, KIND_START);
            end
            PH_START:
            begin
                // a pause taken during the break lands here
                if (!port_running[p])
                    port_phase[p] = PH_IDLE;
                else
                begin
                    port_phase[p] = PH_SLOTS;
                    slot_pos[p]   = '0;
                    emits = 1'b1;
                    sym   = make_symbol(it.port, frame_bytes[base], 1'b0, KIND_SLOT);
                end
            end
            PH_SLOTS:
            begin
                if (int'(slot_pos[p]) + 1 < SLOTS)
                begin
                    slot_pos[p] = slot_pos[p] + 1'b1;
                    emits = 1'b1;
                    sym   = make_symbol(it.port, frame_bytes[base + int'(slot_pos[p])],
                                        1'b0, KIND_SLOT);
                end
                else
                begin
                    // end of frame: next break, or idle when paused
                    slot_pos[p] = '0;
                    if (!port_running[p])
                        port_phase[p] = PH_IDLE;
                    else
                    begin
                        port_phase[p] = PH_BREAK;
                        emits = 1'b1;
                        sym   = make_symbol(it.port, NULL_BYTE, 1'b1, KIND_BREAK);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // sample all channels at the clock edge
    always @(posedge clk or negedge rst_n)
    begin
        item_t   it;
        symbol_t got;
        symbol_t want;
        symbol_t sym;
        bit      emits;
        if (!rst_n)
        begin
            port_mask = '0;
            for (int p = 0; p < PORTS; p++)
            begin
                port_running[p] = 1'b0;
                port_phase[p]   = PH_IDLE;
                slot_pos[p]     = '0;
            end
            for (int i = 0; i < PORTS * SLOTS; i++)
                frame_bytes[i] = '0;
            symbols_due.delete();
            pending <= 0;
            errors  <= fail_count;
        end
        else
        begin
            // result word against the oldest expected symbol
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = make_symbol(m_axis_tdata[1:0], m_axis_tdata[9:2], m_axis_tdata[10],
                                  m_axis_tuser);
                if (symbols_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("%0t: unexpected word port %0d byte %02h half %0d kind %0d",
                                 $realtime, got.port, got.sym_byte, got.half_rate, got.kind);
                    fail_count++;
                end
                else
                begin
                    want = symbols_due.pop_front();
                    if (got.port !== want.port || got.sym_byte !== want.sym_byte
                        || got.half_rate !== want.half_rate || got.kind !== want.kind)
                    begin
                        if (fail_count < 10)
                        begin
                            $write("%0t: mismatch exp port %0d byte %02h half %0d kind %0d,",
                                   $realtime, want.port, want.sym_byte, want.half_rate,
                                   want.kind);
                            $display(" got port %0d byte %02h half %0d kind %0d",
                                     got.port, got.sym_byte, got.half_rate, got.kind);
                        end
                        fail_count++;
                    end
                end
            end
            // mask write
            if (cfg_valid && cfg_ready)
                port_mask = cfg_data;
            // input word
            if (s_axis_tvalid && s_axis_tready)
            begin
                it.cmd          = s_axis_tuser;
                it.port         = s_axis_tdata[1:0];
                it.slot_address = s_axis_tdata[10:2];
                it.slot_value   = s_axis_tdata[18:11];
                it.enable       = s_axis_tdata[19];
                advance_port(it, emits, sym);
                if (emits)
                    symbols_due.push_back(sym);
            end
            pending <= symbols_due.size();
            errors  <= fail_count;
        end
    end

endmodule

// ===== tb/tb.sv =====
// tb: stimulus and verdict for dmx512_frame_transmit_sequencer_top
// depends on dfts_pkg, the sequencer rtl and dfts_symbol_checker
`timescale 1ns / 1ps

module tb;
    import dfts_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int HOLD_AT     = 100;
    localparam int HOLD_CYCLES = 300;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;     // port[1:0], slot_address[10:2],
                                        // slot_value[18:11], enable[19], zero[23:20]
    logic [1:0]  s_axis_tuser = '0;     // cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // out_port[1:0], symbol_byte[9:2], half_rate[10]
    logic [1:0]  m_axis_tuser;          // symbol_kind

    int mismatches;
    int outstanding;
    int cycles = 0;
    bit src_steady = 1'b0;

    dmx512_frame_transmit_sequencer_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    dfts_symbol_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (mismatches),
        .pending       (outstanding)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    // result side: random stalls, one long hold-off, one stretch always ready
    initial
    begin
        int taken;
        int hold_left;
        bit held;
        taken     = 0;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                taken++;
            if (!held && taken >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (taken >= 400 && taken < 700)
                m_axis_tready <= 1'b1;
            else
                m_axis_tready <= ($urandom_range(99) >= 32);
        end
    end

    // offer one input word, with a random gap ahead of it unless src_steady is set
    task automatic offer(input logic [CMD_W-1:0] cmd, input logic [PORT_W-1:0] port,
                         input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] value,
                         input logic en);
        while (!src_steady && $urandom_range(99) < 32)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, en, value, addr, port};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    // stop sending and wait until every expected word has come, plus the latency
    task automatic quiesce();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_mask(input logic [MASK_W-1:0] mask);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_data  <= mask;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // one port through a whole frame, with slot writes and noise mixed in
    task automatic frame_run(input logic [PORT_W-1:0] port, input int pause_at,
                             input int drain_at);
        int sent;
        int r;
        offer(CMD_ENABLE, port, ADDR_W'($urandom_range(511)), BYTE_W'($urandom_range(255)),
              1'b1);
        sent = 0;
        while (sent < 516)
        begin
            r = $urandom_range(99);
            if (r < 10)
                offer(CMD_WRITE, port, ADDR_W'($urandom_range(511)),
                      BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            else if (r < 13)
                offer(CMD_W'($urandom_range(3)), PORT_W'($urandom_range(3)),
                      ADDR_W'($urandom_range(511)), BYTE_W'($urandom_range(255)),
                      1'($urandom_range(1)));
            else
            begin
                offer(CMD_FINISHED, port, ADDR_W'($urandom_range(511)),
                      BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
                sent++;
                if (sent == pause_at)
                    offer(CMD_ENABLE, port, ADDR_W'($urandom_range(511)),
                          BYTE_W'($urandom_range(255)), 1'b0);
                if (sent == drain_at)
                    quiesce();
            end
        end
    endtask

    // random words over all ports and commands
    task automatic random_mix(input int count);
        int r;
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(99);
            if (r < 45)
                offer(CMD_FINISHED, PORT_W'($urandom_range(3)), ADDR_W'($urandom_range(511)),
                      BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            else if (r < 70)
                offer(CMD_WRITE, PORT_W'($urandom_range(3)), ADDR_W'($urandom_range(511)),
                      BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
            else if (r < 92)
                offer(CMD_ENABLE, PORT_W'($urandom_range(3)), ADDR_W'($urandom_range(511)),
                      BYTE_W'($urandom_range(255)), ($urandom_range(99) < 60));
            else
                offer(CMD_UNUSED, PORT_W'($urandom_range(3)), ADDR_W'($urandom_range(511)),
                      BYTE_W'($urandom_range(255)), 1'($urandom_range(1)));
        end
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // mask still clear: only the write takes effect
        offer(CMD_ENABLE, 2'd0, 9'd0, 8'h00, 1'b1);
        offer(CMD_FINISHED, 2'd1, 9'd0, 8'h00, 1'b0);
        offer(CMD_WRITE, 2'd0, 9'd5, 8'h3C, 1'b0);
        load_mask(4'hF);

        // directed words
        offer(CMD_WRITE, 2'd0, 9'd0, 8'hA5, 1'b0);
        offer(CMD_WRITE, 2'd0, 9'd511, 8'hFF, 1'b0);
        offer(CMD_WRITE, 2'd1, 9'd0, 8'h00, 1'b0);
        offer(CMD_WRITE, 2'd3, 9'd511, 8'h5A, 1'b1);
        offer(CMD_FINISHED, 2'd0, 9'd0, 8'h00, 1'b0);   // finished while idle
        offer(CMD_ENABLE, 2'd0, 9'd0, 8'h00, 1'b1);     // break
        offer(CMD_ENABLE, 2'd0, 9'd511, 8'hFF, 1'b1);   // enable while running
        offer(CMD_FINISHED, 2'd0, 9'd0, 8'h00, 1'b0);   // start code
        offer(CMD_FINISHED, 2'd0, 9'd0, 8'h00, 1'b0);   // slot 0
        offer(CMD_FINISHED, 2'd0, 9'd511, 8'hFF, 1'b1); // slot 1
        offer(CMD_ENABLE, 2'd1, 9'd0, 8'h00, 1'b1);
        offer(CMD_ENABLE, 2'd1, 9'd0, 8'h00, 1'b0);     // pause right after the break
        offer(CMD_FINISHED, 2'd1, 9'd0, 8'h00, 1'b0);   // start code still goes out
        offer(CMD_FINISHED, 2'd1, 9'd0, 8'h00, 1'b0);   // then idle
        offer(CMD_ENABLE, 2'd1, 9'd0, 8'h00, 1'b0);     // pause while paused
        offer(CMD_ENABLE, 2'd0, 9'd0, 8'h00, 1'b0);     // pause during slot data
        offer(CMD_ENABLE, 2'd0, 9'd0, 8'h00, 1'b1);     // frame dropped, new break
        offer(CMD_UNUSED, 2'd3, 9'd511, 8'hFF, 1'b1);
        offer(CMD_ENABLE, 2'd2, 9'd0, 8'h00, 1'b1);
        offer(CMD_FINISHED, 2'd3, 9'd0, 8'h00, 1'b0);

        // full frame with no gaps on the input side; the result side holds off inside
        src_steady = 1'b1;
        frame_run(2'd0, -1, -1);
        src_steady = 1'b0;
        // frame paused midway, with a full drain partway through
        frame_run(2'd2, 200, 300);

        load_mask(4'h5);
        random_mix(30);
        load_mask(4'hA);
        random_mix(30);
        load_mask(4'h0);
        random_mix(20);
        load_mask(4'hF);
        random_mix(40);

        quiesce();
        if (mismatches == 0 && outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
